// ===== src/pce_pkg.sv =====
// ----------------------------------------------------------------------------
// pce_pkg: shared types and constants for the Pearson correlation engine
// Holds the controller state, the multiply operation codes, the widths of
// the fixed arithmetic and the command/status bundles.
// ----------------------------------------------------------------------------
package pce_pkg;

  localparam int WORD_W = 64;            // modular width of the moment terms
  localparam int PROD_W = 2 * WORD_W;    // full product of two words
  localparam int Q_W    = 16;            // magnitude search width
  localparam int IDX_W  = 4;             // bit index into the magnitude
  localparam int OUT_W  = 16;

  localparam logic [OUT_W-1:0] SAT_POS = 16'h7FFF;
  localparam logic [OUT_W-1:0] SAT_NEG = 16'h8000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_START,
    S_MUL_WAIT,
    S_CHECK,
    S_SRCH_INIT,
    S_SRCH_ADD,
    S_SRCH_CMP,
    S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    OP_N_CROSS,   // N * sum(ab)
    OP_A_B,       // sum(a) * sum(b)
    OP_N_AA,      // N * sum(aa)
    OP_A_A,       // sum(a)^2
    OP_N_BB,      // N * sum(bb)
    OP_B_B,       // sum(b)^2
    OP_VAR,       // va * vb
    OP_MAG        // |num|^2
  } op_t;

  typedef struct packed {
    logic             accum;
    logic             clear;
    logic             mul_start;
    logic             store;
    op_t              op;
    logic             srch_init;
    logic             srch_add;
    logic             srch_cmp;
    logic [IDX_W-1:0] bit_idx;
    logic             emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic var_zero;
  } dp_status_t;

endpackage

// ===== src/pce_mul.sv =====
// ----------------------------------------------------------------------------
// pce_mul: radix-2 shift-add multiplier
// Unsigned word by word multiply, one multiplier bit per cycle; done pulses
// for one cycle when the full product is ready.
// ----------------------------------------------------------------------------
module pce_mul (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pce_pkg::WORD_W-1:0] x,
  input  logic [pce_pkg::WORD_W-1:0] y,
  output logic                       done,
  output logic [pce_pkg::PROD_W-1:0] prod
);

  import pce_pkg::*;

  localparam int CNT_W = $clog2(WORD_W);

  logic [PROD_W-1:0] mcand;
  logic [WORD_W-1:0] mplier;
  logic [CNT_W-1:0]  cnt;
  logic              run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(WORD_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod   <= '0;
      mcand  <= PROD_W'(x);
      mplier <= y;
    end else if (run) begin
      if (mplier[0]) begin
        prod <= prod + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

endmodule

// ===== src/pce_datapath.sv =====
// ----------------------------------------------------------------------------
// pce_datapath: moment sums, multiply unit and magnitude search
// Accumulates the six sums per beat, forms the numerator and variance terms
// with the shared multiplier, then finds the magnitude bit by bit.
// ----------------------------------------------------------------------------
module pce_datapath #(
  parameter int MAX_PIXELS    = 4194304,
  parameter int FRACTION_BITS = 15
) (
  input  logic                       clk,
  input  logic                       rst,
  input  pce_pkg::ctrl_cmd_t         cmd,
  output pce_pkg::dp_status_t        status,
  input  logic [7:0]                 pixel_a,
  input  logic [7:0]                 pixel_b,
  output logic                       result_valid,
  output logic signed [pce_pkg::OUT_W-1:0] correlation,
  output logic                       defined
);

  import pce_pkg::*;

  localparam int CNT_W = $clog2(MAX_PIXELS + 1);
  localparam int SUM_W = CNT_W + 8;
  localparam int SQ_W  = CNT_W + 16;
  localparam int RHS_W = PROD_W + 2 * FRACTION_BITS;
  localparam int ACC_W = PROD_W + 2 * Q_W + 2;
  localparam int SW    = (RHS_W > ACC_W ? RHS_W : ACC_W) + 1;

  logic [CNT_W-1:0] pixel_count;
  logic [SUM_W-1:0] sum_first, sum_second;
  logic [SQ_W-1:0]  sum_first_squared, sum_second_squared, sum_cross;

  logic [WORD_W-1:0] p0, num, va, vb, mag, mx, my;
  logic [PROD_W-1:0] den, prod;
  logic [SW-1:0]     rhs, q_acc, r_acc, tmp, cand;
  logic [Q_W-1:0]    q;
  logic              neg, mul_done;

  // moment sums, one beat per cycle while the sequencer is idle, up to MAX_PIXELS
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      pixel_count        <= '0;
      sum_first          <= '0;
      sum_second         <= '0;
      sum_first_squared  <= '0;
      sum_second_squared <= '0;
      sum_cross          <= '0;
    end else if (cmd.accum && pixel_count < CNT_W'(MAX_PIXELS)) begin
      pixel_count        <= pixel_count + 1'b1;
      sum_first          <= sum_first + SUM_W'(pixel_a);
      sum_second         <= sum_second + SUM_W'(pixel_b);
      sum_first_squared  <= sum_first_squared + SQ_W'(16'(pixel_a) * 16'(pixel_a));
      sum_second_squared <= sum_second_squared + SQ_W'(16'(pixel_b) * 16'(pixel_b));
      sum_cross          <= sum_cross + SQ_W'(16'(pixel_a) * 16'(pixel_b));
    end
  end

  assign neg = num[WORD_W-1];
  assign mag = neg ? (WORD_W'(0) - num) : num;

  always_comb begin
    case (cmd.op)
      OP_N_CROSS: begin mx = WORD_W'(pixel_count); my = WORD_W'(sum_cross); end
      OP_A_B:     begin mx = WORD_W'(sum_first);   my = WORD_W'(sum_second); end
      OP_N_AA:    begin mx = WORD_W'(pixel_count); my = WORD_W'(sum_first_squared); end
      OP_A_A:     begin mx = WORD_W'(sum_first);   my = WORD_W'(sum_first); end
      OP_N_BB:    begin mx = WORD_W'(pixel_count); my = WORD_W'(sum_second_squared); end
      OP_B_B:     begin mx = WORD_W'(sum_second);  my = WORD_W'(sum_second); end
      OP_VAR:     begin mx = va;                   my = vb; end
      OP_MAG:     begin mx = mag;                  my = mag; end
      default:    begin mx = '0;                   my = '0; end
    endcase
  end

  pce_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .x     (mx),
    .y     (my),
    .done  (mul_done),
    .prod  (prod)
  );

  // keep the moment-term products modulo the word; den and rhs keep the full product
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      case (cmd.op)
        OP_N_CROSS, OP_N_AA, OP_N_BB: p0 <= prod[WORD_W-1:0];
        OP_A_B:  num <= p0 - prod[WORD_W-1:0];
        OP_A_A:  va  <= p0 - prod[WORD_W-1:0];
        OP_B_B:  vb  <= p0 - prod[WORD_W-1:0];
        OP_VAR:  den <= prod;
        OP_MAG:  rhs <= SW'(prod) << (2 * FRACTION_BITS);
        default: p0  <= p0;
      endcase
    end
  end

  // q_acc = q^2 * den, r_acc = q * den; try each bit from the top down
  assign cand = q_acc + tmp;

  always_ff @(posedge clk) begin
    if (cmd.srch_init) begin
      q_acc <= '0;
      r_acc <= '0;
      q     <= '0;
    end else if (cmd.srch_add) begin
      tmp <= (r_acc << ({1'b0, cmd.bit_idx} + 1'b1))
           + (SW'(den) << {cmd.bit_idx, 1'b0});
    end else if (cmd.srch_cmp && cand <= rhs) begin
      q_acc          <= cand;
      r_acc          <= r_acc + (SW'(den) << cmd.bit_idx);
      q[cmd.bit_idx] <= 1'b1;
    end
  end

  assign status.mul_done = mul_done;
  assign status.var_zero = (va == '0) || (vb == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      defined <= !status.var_zero;
      if (status.var_zero) begin
        correlation <= '0;
      end else if (neg) begin
        correlation <= q[Q_W-1] ? SAT_NEG : OUT_W'(-q);
      end else begin
        correlation <= q[Q_W-1] ? SAT_POS : q;
      end
    end
  end

endmodule

// ===== src/pce_ctrl.sv =====
// ----------------------------------------------------------------------------
// pce_ctrl: sequencer for the correlation engine
// Runs the multiply sequence after the last beat, then, unless a variance
// is zero, the bitwise search; then the result strobe.
// ----------------------------------------------------------------------------
module pce_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                last_pixel,
  input  pce_pkg::dp_status_t status,
  output pce_pkg::ctrl_cmd_t  cmd,
  output logic                busy
);

  import pce_pkg::*;

  state_t           state, state_next;
  op_t              op, op_next;
  logic [IDX_W-1:0] bit_idx, bit_idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      op      <= OP_N_CROSS;
      bit_idx <= '0;
    end else begin
      state   <= state_next;
      op      <= op_next;
      bit_idx <= bit_idx_next;
    end
  end

  always_comb begin
    state_next   = state;
    op_next      = op;
    bit_idx_next = bit_idx;
    case (state)
      S_IDLE: begin
        if (start && last_pixel) begin
          op_next    = OP_N_CROSS;
          state_next = S_MUL_START;
        end
      end
      S_MUL_START: state_next = S_MUL_WAIT;
      S_MUL_WAIT: begin
        if (status.mul_done) begin
          if (op == OP_B_B) begin
            state_next = S_CHECK;
          end else if (op == OP_MAG) begin
            state_next = S_SRCH_INIT;
          end else begin
            op_next    = op_t'(op + 1'b1);
            state_next = S_MUL_START;
          end
        end
      end
      S_CHECK: begin
        if (status.var_zero) begin
          state_next = S_EMIT;
        end else begin
          op_next    = OP_VAR;
          state_next = S_MUL_START;
        end
      end
      S_SRCH_INIT: begin
        bit_idx_next = '1;
        state_next   = S_SRCH_ADD;
      end
      S_SRCH_ADD: state_next = S_SRCH_CMP;
      S_SRCH_CMP: begin
        if (bit_idx == '0) begin
          state_next = S_EMIT;
        end else begin
          bit_idx_next = bit_idx - 1'b1;
          state_next   = S_SRCH_ADD;
        end
      end
      S_EMIT:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.op      = op;
    cmd.bit_idx = bit_idx;
    busy        = (state != S_IDLE);
    case (state)
      S_IDLE:      cmd.accum     = start;
      S_MUL_START: cmd.mul_start = 1'b1;
      S_MUL_WAIT:  cmd.store     = status.mul_done;
      S_CHECK:     cmd.clear     = 1'b1;
      S_SRCH_INIT: cmd.srch_init = 1'b1;
      S_SRCH_ADD:  cmd.srch_add  = 1'b1;
      S_SRCH_CMP:  cmd.srch_cmp  = 1'b1;
      S_EMIT:      cmd.emit      = 1'b1;
      default:     cmd.accum     = 1'b0;
    endcase
  end

endmodule

// ===== src/pearson_correlation_engine.sv =====
// ----------------------------------------------------------------------------
// pearson_correlation_engine: Pearson correlation of two grey images
// Streams pixel pairs into exact moment sums and, on the pair marked last,
// computes r = (N*Sab - Sa*Sb) / sqrt((N*Saa - Sa^2)(N*Sbb - Sb^2)) in
// signed fixed point with FRACTION_BITS fraction bits.
//
//   channel  handshake          payload
//   -------  -----------------  -----------------------------------------
//   pixels   start / busy       pixel_a, pixel_b, last_pixel
//   result   result_valid       correlation, defined
//
// One beat per cycle while busy is low; an unmarked beat only adds to the
// sums. After the marked beat busy stays high for the result phase: six
// shift-add multiplies for the moment terms, two more for the denominator
// and squared numerator, then a search over 16 bits (when a variance is
// zero, the last two multiplies and the search are skipped).
// Reset clears the sums, the sequencer and the strobe at once.
// The result beat is on the outputs for exactly one cycle; the receiver
// cannot stall it, and the next image may start in that same cycle.
// ----------------------------------------------------------------------------
module pearson_correlation_engine #(
  parameter int MAX_PIXELS    = 4194304,
  parameter int FRACTION_BITS = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         pixel_a,
  input  logic [7:0]         pixel_b,
  input  logic               last_pixel,
  output logic               result_valid,
  output logic signed [15:0] correlation,
  output logic               defined
);

  import pce_pkg::*;

  ctrl_cmd_t  cmd;     // sequencer commands for this cycle
  dp_status_t status;  // multiply done and zero variance flags

  // sequencer: accept beats while idle, run the result phase after the last
  pce_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .last_pixel (last_pixel),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy)
  );

  // sums, shared multiplier, magnitude search and result registers
  pce_datapath #(
    .MAX_PIXELS    (MAX_PIXELS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .pixel_a      (pixel_a),
    .pixel_b      (pixel_b),
    .result_valid (result_valid),
    .correlation  (correlation),
    .defined      (defined)
  );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the Pearson correlation engine
// Feeds directed images and images of random size and content, predicts
// each correlation result from exact moment sums and an integer magnitude
// search, and checks every result beat field by field in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int MAX_PIX   = 4194304;
  localparam int FRAC_BITS = 15;

  typedef struct {
    logic [7:0] a;
    logic [7:0] b;
    logic       last;
    int         gap;
  } pixel_beat_t;

  typedef struct {
    logic signed [15:0] corr;
    logic               def;
  } corr_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [7:0]         pixel_a = '0;
  logic [7:0]         pixel_b = '0;
  logic               last_pixel = 1'b0;
  logic               result_valid;
  logic signed [15:0] correlation;
  logic               defined;

  pixel_beat_t  pending_pixels[$];
  corr_result_t expected_corr[$];

  // Predictor state: exact moment sums of the image in flight.
  longint unsigned cnt, s_a, s_b, s_aa, s_bb, s_ab;

  int  mismatches = 0;
  bit  feeding_done = 1'b0;
  int  gap_left = 0;

  pearson_correlation_engine DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .pixel_a(pixel_a), .pixel_b(pixel_b), .last_pixel(last_pixel),
    .result_valid(result_valid), .correlation(correlation), .defined(defined)
  );

  always #1 clk = ~clk;

  // Add one pixel pair to the sums; on the marked pair, queue the result.
  function automatic void accumulate_pixel(logic [7:0] a, logic [7:0] b, logic last);
    longint unsigned num, va, vb, mag, lo, hi, mid;
    logic [255:0] den, rhs, lhs;
    bit neg;
    corr_result_t r;
    if (cnt < MAX_PIX) begin
      cnt++; s_a += a; s_b += b;
      s_aa += a * a; s_bb += b * b; s_ab += a * b;
    end
    if (!last) return;
    num = cnt * s_ab - s_a * s_b;
    va  = cnt * s_aa - s_a * s_a;
    vb  = cnt * s_bb - s_b * s_b;
    cnt = 0; s_a = 0; s_b = 0; s_aa = 0; s_bb = 0; s_ab = 0;
    if (va == 0 || vb == 0) begin
      r.corr = '0;
      r.def  = 1'b0;
    end else begin
      neg = num[63];
      mag = neg ? -num : num;
      den = 256'(va) * 256'(vb);
      rhs = (256'(mag) * 256'(mag)) << (2 * FRAC_BITS);
      lo = 0;
      hi = 32768;
      // largest magnitude q with q^2 * den <= rhs
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        lhs = 256'(mid * mid) * den;
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      if (neg) r.corr = 16'(-lo);
      else r.corr = (lo > 32767) ? 16'sd32767 : 16'(lo);
      r.def = 1'b1;
    end
    expected_corr.push_back(r);
  endfunction

  // Driver: hold each beat until busy is low at the edge, then advance.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && busy) begin
      // hold the current beat
    end else begin
      if (start) accumulate_pixel(pixel_a, pixel_b, last_pixel);
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_pixels.size() > 0) begin
        pixel_beat_t p;
        p = pending_pixels.pop_front();
        if (p.gap > 0) begin
          // idle first, then push this beat back to the front
          pending_pixels.push_front('{a: p.a, b: p.b, last: p.last, gap: 0});
          gap_left <= p.gap - 1;
          start <= 1'b0;
        end else begin
          pixel_a <= p.a;
          pixel_b <= p.b;
          last_pixel <= p.last;
          start <= 1'b1;
        end
      end else begin
        start <= 1'b0;
        feeding_done <= 1'b1;
      end
    end
  end

  // Monitor: compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (expected_corr.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: correlation=%0d defined=%0d", correlation, defined);
      end else begin
        corr_result_t e;
        e = expected_corr.pop_front();
        if (e.corr !== correlation || e.def !== defined) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected correlation=%0d defined=%0d, got %0d %0d",
                     e.corr, e.def, correlation, defined);
        end
      end
    end
  end

  function automatic int draw_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic void queue_pixel(logic [7:0] a, logic [7:0] b, logic last, bit bursty);
    pending_pixels.push_back('{a: a, b: b, last: last, gap: bursty ? 0 : draw_gap()});
  endfunction

  // Build one image; style picks the relation between the two images.
  function automatic void queue_image(int n, int style, bit bursty);
    logic [7:0] a, b;
    int k;
    k = $urandom_range(0, 255);
    for (int i = 0; i < n; i++) begin
      a = 8'($urandom_range(0, 255));
      case (style)
        0: b = 8'($urandom_range(0, 255));
        1: b = a;
        2: b = 8'd255 - a;
        3: b = 8'(k);
        4: begin b = a; a = 8'(k); end
        default: b = 8'(a + $urandom_range(0, 20));
      endcase
      queue_pixel(a, b, i == n - 1, bursty);
    end
  endfunction

  initial begin
    cnt = 0; s_a = 0; s_b = 0; s_aa = 0; s_bb = 0; s_ab = 0;
    // Directed: single pair (zero variance), extremes, perfect +/- correlation.
    queue_pixel(8'd0, 8'd255, 1'b1, 1'b0);
    queue_pixel(8'd0, 8'd0, 1'b0, 1'b0);
    queue_pixel(8'd255, 8'd255, 1'b1, 1'b0);
    queue_pixel(8'd0, 8'd255, 1'b0, 1'b0);
    queue_pixel(8'd255, 8'd0, 1'b1, 1'b0);
    queue_pixel(8'd7, 8'd3, 1'b0, 1'b0);
    queue_pixel(8'd7, 8'd200, 1'b1, 1'b0);
    queue_pixel(8'd10, 8'd1, 1'b0, 1'b1);
    queue_pixel(8'd20, 8'd2, 1'b0, 1'b1);
    queue_pixel(8'd40, 8'd3, 1'b1, 1'b1);
    queue_pixel(8'haa, 8'h55, 1'b0, 1'b0);
    queue_pixel(8'h55, 8'haa, 1'b0, 1'b0);
    queue_pixel(8'hff, 8'h00, 1'b1, 1'b0);
    // Random images, mostly small, a few larger.
    while (pending_pixels.size() < 1900) begin
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
      queue_image(n, $urandom_range(0, 5), $urandom_range(0, 3) == 0);
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    wait (feeding_done && expected_corr.size() == 0);
    repeat (700) @(posedge clk);
    if (mismatches == 0 && expected_corr.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #20000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
